// File: rtl/avra_pkg.sv
// Package for the aligned vector run allocator: payload types, codes and sizes.
package avra_pkg;

    localparam int MAX_RUN    = 16;
    localparam int ROW_SIZE   = 16;
    localparam int NUM_ROWS   = 16;
    localparam int ENTRY_W    = 2;
    localparam int ROW_W      = ROW_SIZE * ENTRY_W;

    // Commands
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;

    // Result status
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_INVALID     = 2'd1;
    localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;
    localparam logic [1:0] STAT_NO_ROOM     = 2'd3;

    // Map entry codes
    localparam logic [1:0] VEC_FREE  = 2'd0;
    localparam logic [1:0] VEC_MSI   = 2'd1;
    localparam logic [1:0] VEC_OTHER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MSI_ENABLED = 2'd0;
    localparam logic [1:0] CFG_HIGHEST_ROW = 2'd1;
    localparam logic [1:0] CFG_LOWEST_ROW  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [8:0]  count;
        logic [7:0]  base_vector;
        logic [63:0] target_set;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] run_base;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALLOC = 4'b0010,
        S_FREE  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

// File: rtl/aligned_vector_run_allocator_top.sv
// Aligned vector run allocator: 256-entry vector map with a row-serial scan.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one command
//   transaction: allocate a run of 1..16 vectors, free a run, or reserve one
//   vector for another owner. Every command produces exactly one result
//   transaction on the output channel (o_out_valid / i_out_ready / o_out_data)
//   with a status and, for a successful allocate, the run base.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes msi_enabled, highest_row, lowest_row; always ready, and is meant
//   to be written only while no command is in flight.
// Throughput:
//   One command at a time. Reserve, rejected allocates and unknown commands
//   go from idle to the done state and then to the result register. Allocate
//   scans rows (1..16), one 16-vector row per cycle through a single fit checker.
//   Free touches rows (1..16), one row read-modify-write per cycle.
//   The map row register file has one read and one write port, which sets
//   the one-row-per-cycle pace.
// Reset: synchronous, active low; the whole map returns to free and the
//   config registers take their defaults (0, 13, 3).
// Stall: a finished result is held in the output register; the sequencer
//   waits in its final state until that register can take the new result.
module aligned_vector_run_allocator_top
    import avra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    // Vector map: one register per 16-vector row, 2 bits per entry
    logic [ROW_W-1:0] r_map [NUM_ROWS];

    // Config
    logic       r_msi_en;
    logic [3:0] r_high_row;
    logic [3:0] r_low_row;

    // Sequencer
    t_state     r_state, n_state;
    t_in        r_req, n_req;
    logic [3:0] r_row, n_row;
    logic [3:0] r_last, n_last;
    logic [7:0] r_end, n_end;
    t_out       r_res, n_res;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;

    // Row datapath
    logic [3:0]       rd_row;
    logic [ROW_W-1:0] row_data;
    logic [15:0]      free_mask;
    logic [4:0]       run_n;
    logic [16:0]      run_ones;
    logic [15:0]      run_mask;
    logic [15:0]      place_mask;
    logic [3:0]       align_mask;
    logic [15:0]      fits;
    logic             hit;
    logic [3:0]       hit_base;
    logic [ROW_W-1:0] alloc_row;
    logic [ROW_W-1:0] free_row;
    logic [ROW_W-1:0] rsv_row;
    logic [9:0]       end_sum;
    logic             in_acc;
    logic             out_free;

    // Map write port
    logic             wr_en;
    logic [3:0]       wr_row;
    logic [ROW_W-1:0] wr_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Single read address: incoming reserve target when idle, else the scan row
    assign rd_row   = (r_state == S_IDLE) ? i_in_data.base_vector[7:4] : r_row;
    assign row_data = r_map[rd_row];

    // Fit checker: all aligned candidate bases of one row in parallel
    always_comb begin
        for (int j = 0; j < ROW_SIZE; j++) begin
            free_mask[j] = (row_data[j*ENTRY_W +: ENTRY_W] == VEC_FREE);
        end
        run_n    = r_req.count[4:0];
        run_ones = (17'd1 << run_n) - 17'd1;
        run_mask = run_ones[15:0];
        if (run_n <= 5'd1) begin
            align_mask = 4'b0000;
        end else if (run_n <= 5'd2) begin
            align_mask = 4'b0001;
        end else if (run_n <= 5'd4) begin
            align_mask = 4'b0011;
        end else if (run_n <= 5'd8) begin
            align_mask = 4'b0111;
        end else begin
            align_mask = 4'b1111;
        end
        for (int b = 0; b < ROW_SIZE; b++) begin
            fits[b] = (((free_mask >> b) & run_mask) == run_mask)
                   && ((6'(b) + {1'b0, run_n}) <= 6'(ROW_SIZE))
                   && ((4'(b) & align_mask) == 4'd0);
        end
        // lowest fitting base wins
        hit      = 1'b0;
        hit_base = 4'd0;
        for (int b = ROW_SIZE - 1; b >= 0; b--) begin
            if (fits[b]) begin
                hit      = 1'b1;
                hit_base = 4'(b);
            end
        end
        place_mask = run_mask << hit_base;
        for (int j = 0; j < ROW_SIZE; j++) begin
            alloc_row[j*ENTRY_W +: ENTRY_W] =
                place_mask[j] ? VEC_MSI : row_data[j*ENTRY_W +: ENTRY_W];
        end
    end

    // Free: release message-held entries of this row inside [base, end]
    always_comb begin
        for (int j = 0; j < ROW_SIZE; j++) begin
            if (({r_row, 4'(j)} >= r_req.base_vector) && ({r_row, 4'(j)} <= r_end)
                    && (row_data[j*ENTRY_W +: ENTRY_W] == VEC_MSI)) begin
                free_row[j*ENTRY_W +: ENTRY_W] = VEC_FREE;
            end else begin
                free_row[j*ENTRY_W +: ENTRY_W] = row_data[j*ENTRY_W +: ENTRY_W];
            end
        end
    end

    // Reserve: one entry becomes other-owned
    always_comb begin
        for (int j = 0; j < ROW_SIZE; j++) begin
            rsv_row[j*ENTRY_W +: ENTRY_W] = (4'(j) == i_in_data.base_vector[3:0])
                ? VEC_OTHER : row_data[j*ENTRY_W +: ENTRY_W];
        end
    end

    assign end_sum = {2'b00, i_in_data.base_vector} + {1'b0, i_in_data.count} - 10'd1;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_row       = r_row;
        n_last      = r_last;
        n_end       = r_end;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_row      = r_row;
        wr_data     = alloc_row;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req          = i_in_data;
                    n_res.status   = STAT_OK;
                    n_res.run_base = 8'd0;
                    n_state        = S_DONE;
                    case (i_in_data.cmd)
                        CMD_ALLOC: begin
                            if ((i_in_data.target_set == 64'd0)
                                    || (i_in_data.count == 9'd0)) begin
                                n_res.status = STAT_INVALID;
                            end else if (!r_msi_en) begin
                                n_res.status = STAT_UNSUPPORTED;
                            end else if (i_in_data.count > 9'(MAX_RUN)) begin
                                n_res.status = STAT_INVALID;
                            end else if (r_high_row < r_low_row) begin
                                n_res.status = STAT_NO_ROOM;
                            end else begin
                                n_row   = r_high_row;
                                n_state = S_ALLOC;
                            end
                        end
                        CMD_FREE: begin
                            if (i_in_data.count != 9'd0) begin
                                n_end   = end_sum[9:8] != 2'b00 ? 8'hFF : end_sum[7:0];
                                n_last  = end_sum[9:8] != 2'b00 ? 4'hF : end_sum[7:4];
                                n_row   = i_in_data.base_vector[7:4];
                                n_state = S_FREE;
                            end
                        end
                        CMD_RESERVE: begin
                            wr_en   = 1'b1;
                            wr_row  = i_in_data.base_vector[7:4];
                            wr_data = rsv_row;
                        end
                        default: begin
                            n_res.status = STAT_INVALID;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (hit) begin
                    wr_en          = 1'b1;
                    wr_row         = r_row;
                    wr_data        = alloc_row;
                    n_res.run_base = {r_row, hit_base};
                    n_state        = S_DONE;
                end else if (r_row == r_low_row) begin
                    n_res.status = STAT_NO_ROOM;
                    n_state      = S_DONE;
                end else begin
                    n_row = r_row - 4'd1;
                end
            end
            S_FREE: begin
                wr_en   = 1'b1;
                wr_row  = r_row;
                wr_data = free_row;
                if (r_row == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_row = r_row + 4'd1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_msi_en    <= 1'b0;
            r_high_row  <= 4'd13;
            r_low_row   <= 4'd3;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MSI_ENABLED: r_msi_en   <= i_cfg_data[0];
                    CFG_HIGHEST_ROW: r_high_row <= i_cfg_data;
                    CFG_LOWEST_ROW:  r_low_row  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_row  <= n_row;
        r_last <= n_last;
        r_end  <= n_end;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // Map rows: cleared to free at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_map[r] <= '0;
            end
        end else if (wr_en) begin
            r_map[wr_row] <= wr_data;
        end
    end

endmodule

// File: tb/testbench.sv
// Testbench for aligned_vector_run_allocator_top: directed and random command traffic with a vector map scoreboard.
`timescale 1ns / 100ps

module testbench;
    import avra_pkg::*;

    // cmd 3 has no package name; the block must answer it as invalid.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Worst quiet stretch of a correct run: a long sender gap, the block's
    // slowest command and a long receiver stall. Taken well over.
    localparam int STALL_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE  = 180;
    localparam int NUM_PHASES       = 8;
    localparam int SETTLE_CYCLES    = 20;

    typedef struct {
        int unsigned first;
        int unsigned span;
    } t_run;

    // Mirror of the vector map and the scan registers. Every accepted command
    // transaction is applied here and leaves one predicted reply behind.
    class run_allocation_tracker;
        logic [1:0] vec_state [256];
        bit         msi_on;
        bit [3:0]   top_row;
        bit [3:0]   bottom_row;
        t_out       awaited_replies [$];
        t_run       live_runs [$];
        int         failures;

        function new();
            foreach (vec_state[v]) vec_state[v] = VEC_FREE;
            msi_on     = 1'b0;
            top_row    = 4'd13;
            bottom_row = 4'd3;
            failures   = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [3:0] value);
            case (index)
                CFG_MSI_ENABLED: msi_on     = value[0];
                CFG_HIGHEST_ROW: top_row    = value;
                CFG_LOWEST_ROW:  bottom_row = value;
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        // Rows high to low, aligned bases low to high, first wholly free run wins.
        function t_out allocate_run(int unsigned n, logic [63:0] cpus);
            t_out        reply;
            int unsigned align;
            int          row;
            int unsigned start;
            int unsigned i;
            bit          clear;
            t_run        run;
            reply.status   = STAT_OK;
            reply.run_base = '0;
            if (cpus == '0 || n == 0) begin
                reply.status = STAT_INVALID;
            end else if (!msi_on) begin
                reply.status = STAT_UNSUPPORTED;
            end else if (n > MAX_RUN) begin
                reply.status = STAT_INVALID;
            end else begin
                align = 1;
                while (align < n) align = align << 1;
                reply.status = STAT_NO_ROOM;
                for (row = top_row; row >= int'(bottom_row) && reply.status == STAT_NO_ROOM;
                     row--) begin
                    for (start = row * ROW_SIZE;
                         start + n <= row * ROW_SIZE + ROW_SIZE && reply.status == STAT_NO_ROOM;
                         start += align) begin
                        clear = 1'b1;
                        for (i = 0; i < n; i++)
                            if (vec_state[start + i] != VEC_FREE) clear = 1'b0;
                        if (clear) begin
                            for (i = 0; i < n; i++) vec_state[start + i] = VEC_MSI;
                            reply.status   = STAT_OK;
                            reply.run_base = start[7:0];
                            run.first      = start;
                            run.span       = n;
                            live_runs.push_back(run);
                        end
                    end
                end
            end
            return reply;
        endfunction

        function void note_command(t_in item);
            t_out        reply;
            int unsigned v;
            reply.status   = STAT_OK;
            reply.run_base = '0;
            case (item.cmd)
                CMD_ALLOC: reply = allocate_run(item.count, item.target_set);
                CMD_FREE: begin
                    // Only message-held entries go back; the range stops at 255.
                    for (v = item.base_vector;
                         v < int'(item.base_vector) + int'(item.count) && v <= 255; v++)
                        if (vec_state[v] == VEC_MSI) vec_state[v] = VEC_FREE;
                end
                CMD_RESERVE: vec_state[item.base_vector] = VEC_OTHER;
                default: reply.status = STAT_INVALID;
            endcase
            awaited_replies.push_back(reply);
        endfunction

        function void check_reply(t_out got);
            t_out want;
            if (awaited_replies.size() == 0) begin
                flag($sformatf("result with none expected: status=%0d run_base=%0d",
                               got.status, got.run_base));
            end else begin
                want = awaited_replies.pop_front();
                if (got.status !== want.status)
                    flag($sformatf("status mismatch: expected %0d, got %0d",
                                   want.status, got.status));
                if (got.run_base !== want.run_base)
                    flag($sformatf("run_base mismatch: expected %0d, got %0d",
                                   want.run_base, got.run_base));
            end
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction

        // Pulls a random run that an earlier allocate handed out.
        function t_run take_run();
            int   idx;
            t_run run;
            idx = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            return run;
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in        in_data;
    logic       out_valid;
    logic       out_ready;
    t_out       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    run_allocation_tracker book;
    bit steady = 1'b0;    // no gaps and no stalls while set
    int idle_cycles = 0;

    aligned_vector_run_allocator_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short idle spans, now and then a long one.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: ready changes at the falling edge only.
    initial begin : receiver
        int hold;
        out_ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold = idle_span();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) book.check_reply(out_data);
    end

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("aligned_vector_run_allocator_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One command transaction. Valid stays up between back-to-back commands.
    task automatic send(input t_in item);
        int gap;
        gap = idle_span();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        book.note_command(item);
    endtask

    // Sender holds off until every reply is back; the block is then idle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] index, input logic [3:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        book.write_reg(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input bit msi, input bit [3:0] hi, input bit [3:0] lo);
        drain();
        write_cfg(CFG_MSI_ENABLED, {3'b000, msi});
        write_cfg(CFG_HIGHEST_ROW, hi);
        write_cfg(CFG_LOWEST_ROW, lo);
    endtask

    function automatic t_in mk(logic [1:0] c, int n, int b, logic [63:0] cpus);
        t_in item;
        item.cmd         = c;
        item.count       = 9'(n);
        item.base_vector = 8'(b);
        item.target_set  = cpus;
        return item;
    endfunction

    // Random traffic: mostly allocates paired with frees of runs that were
    // handed out, plus reserves, stray frees, unused commands and rare wipes.
    function automatic t_in random_command();
        t_in  item;
        int   pick;
        int   sel;
        t_run run;
        item.cmd         = CMD_ALLOC;
        item.count       = 9'($urandom_range(0, 511));
        item.base_vector = 8'($urandom_range(0, 255));
        item.target_set  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 57) begin
            sel = $urandom_range(0, 99);
            if (sel < 85)
                item.count = 9'($urandom_range(1, MAX_RUN));
            else if (sel < 90)
                item.count = '0;
            else
                item.count = 9'($urandom_range(MAX_RUN + 1, 511));
            sel = $urandom_range(0, 99);
            if (sel < 5)
                item.target_set = '0;
            else if (sel < 10)
                item.target_set = 64'd1 << $urandom_range(0, 63);
        end else if (pick < 87) begin
            item.cmd = CMD_FREE;
            if (book.live_runs.size() > 0 && $urandom_range(0, 4) != 0) begin
                run = book.take_run();
                item.base_vector = 8'(run.first);
                item.count = 9'(run.span + (($urandom_range(0, 3) == 0) ?
                                            $urandom_range(1, 4) : 0));
            end else if ($urandom_range(0, 9) != 0) begin
                item.count = 9'($urandom_range(0, 40));
            end
        end else if (pick < 94) begin
            // Keep most foreign owners in the edge rows so the scan range stays usable.
            item.cmd = CMD_RESERVE;
            sel = $urandom_range(0, 9);
            if (sel < 4)
                item.base_vector = 8'($urandom_range(0, 31));
            else if (sel < 7)
                item.base_vector = 8'($urandom_range(240, 255));
        end else if (pick < 99) begin
            item.cmd = CMD_UNUSED;
        end else begin
            item = mk(CMD_FREE, 256, 0, item.target_set);
        end
        return item;
    endfunction

    initial begin
        book      = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: message interrupts off, check order of rejects.
        send(mk(CMD_ALLOC, 4, 0, 64'd1));
        send(mk(CMD_ALLOC, 0, 0, 64'd1));
        send(mk(CMD_ALLOC, 4, 0, '0));
        send(mk(CMD_UNUSED, 511, 255, '1));

        // Full row range; counts that round up to the next alignment.
        configure(1'b1, 4'd15, 4'd0);
        send(mk(CMD_ALLOC, 1, 0, '1));
        send(mk(CMD_ALLOC, 2, 0, '1));
        send(mk(CMD_ALLOC, 3, 0, '1));
        send(mk(CMD_ALLOC, 5, 0, '1));
        send(mk(CMD_ALLOC, 16, 0, '1));
        send(mk(CMD_ALLOC, 17, 0, '1));
        send(mk(CMD_ALLOC, 256, 0, '1));
        send(mk(CMD_ALLOC, 511, 255, '1));
        // Reserve over a message-held vector, which a free must then skip.
        send(mk(CMD_RESERVE, 0, 240, '1));
        send(mk(CMD_FREE, 16, 240, '1));
        send(mk(CMD_FREE, 20, 250, '1));
        send(mk(CMD_FREE, 0, 224, '1));
        send(mk(CMD_RESERVE, 0, 0, '0));
        send(mk(CMD_FREE, 256, 0, '0));
        send(mk(CMD_ALLOC, 16, 0, 64'h8000_0000_0000_0000));

        // Highest row below lowest: nothing is scanned.
        configure(1'b1, 4'd2, 4'd5);
        send(mk(CMD_ALLOC, 1, 0, '1));

        // Row zero alone, with vector 0 held by another owner.
        configure(1'b1, 4'd0, 4'd0);
        send(mk(CMD_ALLOC, 16, 0, '1));
        send(mk(CMD_ALLOC, 1, 0, '1));
        send(mk(CMD_ALLOC, 2, 0, '1));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: configure(1'b1, 4'd15, 4'd0);
                1: configure(1'b1, 4'd13, 4'd3);
                2: configure(1'b1, 4'd0, 4'd0);
                3: configure(1'b0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                4: configure(1'b1, 4'd3, 4'd12);
                5: configure(1'b1, 4'd15, 4'd15);
                default: configure(1'b1, 4'($urandom_range(0, 15)),
                                   4'($urandom_range(0, 15)));
            endcase
            steady = (phase == 1) || ($urandom_range(0, 4) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send(random_command());
                if ($urandom_range(0, 199) == 0) drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (book.pending() != 0)
            book.flag($sformatf("%0d results never arrived", book.pending()));

        if (book.failures == 0) begin
            $display("aligned_vector_run_allocator_top test passed");
        end else begin
            $display("aligned_vector_run_allocator_top test failed");
        end
        $finish;
    end

endmodule
